// ----- rtl/rts_pkg.sv -----
// Package for the reliable transport sender: item structs, phase and send codes,
// window geometry constants.
// No dependencies.
package rts_pkg;

   localparam int unsigned SEQ_W       = 32;
   localparam int unsigned TIMEOUT_W   = 16;
   localparam int unsigned LEN_W       = 11;
   localparam int unsigned KIND_W      = 3;
   localparam int unsigned PHASE_W     = 3;
   localparam int unsigned CSR_INDEX_W = 2;

   // window geometry: eight slots of 1024 bytes
   localparam int unsigned WINDOW_SLOTS = 8;
   localparam int unsigned CHUNK_BYTES  = 1024;
   localparam int unsigned SLOT_W       = $clog2(WINDOW_SLOTS);
   localparam int unsigned CHUNK_SHIFT  = $clog2(CHUNK_BYTES);
   localparam logic [SEQ_W-1:0] WINDOW_BYTES = SEQ_W'(WINDOW_SLOTS * CHUNK_BYTES);
   localparam logic [LEN_W-1:0] CHUNK_MAX    = LEN_W'(CHUNK_BYTES);

   localparam logic [SEQ_W-1:0]     ISN_RESET     = 32'd5000;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd500;

   // request codes
   localparam logic [1:0] REQ_OPEN   = 2'd0;
   localparam logic [1:0] REQ_HEADER = 2'd1;
   localparam logic [1:0] REQ_CHUNK  = 2'd2;
   localparam logic [1:0] REQ_TICK   = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ISN     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT = 2'd1;

   // link phases
   localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_SYN    = 3'd1;
   localparam logic [PHASE_W-1:0] PH_EST    = 3'd2;
   localparam logic [PHASE_W-1:0] PH_FINW   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_CLOSED = 3'd4;

   // send kinds
   localparam logic [KIND_W-1:0] SEND_NONE      = 3'd0;
   localparam logic [KIND_W-1:0] SEND_SYN       = 3'd1;
   localparam logic [KIND_W-1:0] SEND_HS_ACK    = 3'd2;
   localparam logic [KIND_W-1:0] SEND_DATA      = 3'd3;
   localparam logic [KIND_W-1:0] SEND_RETX      = 3'd4;
   localparam logic [KIND_W-1:0] SEND_FIN       = 3'd5;
   localparam logic [KIND_W-1:0] SEND_FINAL_ACK = 3'd6;

   typedef struct packed {
      logic [1:0]       req_type;
      logic             rx_syn;
      logic             rx_ack;
      logic             rx_fin;
      logic [SEQ_W-1:0] rx_seq;
      logic [SEQ_W-1:0] rx_ack_number;
      logic [LEN_W-1:0] chunk_len;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0]  send_kind;
      logic [SEQ_W-1:0]   send_seq;
      logic [SEQ_W-1:0]   send_ack;
      logic [LEN_W-1:0]   send_len;
      logic [SLOT_W-1:0]  slot;
      logic               chunk_taken;
      logic [PHASE_W-1:0] link_state;
   } rsp_item_type;

endpackage

// ----- rtl/reliable_transport_sender.sv -----
// Reliable transport sender: handshake, sliding window, retransmit and close.
// An accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while the result side is not stalled by rsp_ready.
// Reset (synchronous, active high) clears phase, counters and flags and loads
// register defaults; the slot stores are not cleared.
// Depends on rts_pkg.
module reliable_transport_sender (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  rts_pkg::req_item_type                   req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output rts_pkg::rsp_item_type                   rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [rts_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [rts_pkg::SEQ_W-1:0]               csr_wdata
);

   localparam int unsigned SW = rts_pkg::SEQ_W;
   localparam int unsigned LW = rts_pkg::LEN_W;
   localparam int unsigned NW = rts_pkg::SLOT_W;

   // input and result registers
   logic                  req_valid_ff;
   rts_pkg::req_item_type req_ff;
   logic                  rsp_valid_ff;
   rts_pkg::rsp_item_type rsp_ff;
   rts_pkg::rsp_item_type rsp_in;
   logic                  advance;

   // configuration
   logic [SW-1:0]                 isn_ff;
   logic [rts_pkg::TIMEOUT_W-1:0] timeout_ff;

   // link state
   logic [rts_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [SW-1:0] peer_isn_ff, peer_isn_in;
   logic [SW-1:0] lbs_ff, lbs_in;
   logic [SW-1:0] lba_ff, lba_in;
   logic [SW-1:0] phase_start_ff, phase_start_in;
   logic [SW-1:0] ms_clock_ff, ms_clock_in;
   logic          exhausted_ff, exhausted_in;
   logic          fin_acked_ff, fin_acked_in;
   logic          peer_fin_ff, peer_fin_in;
   logic [SW-1:0] peer_last_ff, peer_last_in;

   // slot stores
   logic [SW-1:0] slot_time_ff [rts_pkg::WINDOW_SLOTS];
   logic [LW-1:0] slot_len_ff  [rts_pkg::WINDOW_SLOTS];
   logic          slot_we;
   logic [NW-1:0] slot_waddr;
   logic [SW-1:0] slot_wtime;
   logic [LW-1:0] slot_wlen;
   logic          slot_len_we;

   // working values
   logic [NW-1:0] slot_sent;
   logic [NW-1:0] slot_acked;
   logic [SW-1:0] ms_next;
   logic [SW-1:0] outstanding;
   logic [SW-1:0] ack_minus_one;
   logic [SW-1:0] lba_new;
   logic          fa_new;
   logic          pf_new;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   assign slot_sent   = lbs_ff[rts_pkg::CHUNK_SHIFT +: NW];
   assign slot_acked  = lba_ff[rts_pkg::CHUNK_SHIFT +: NW];
   assign ms_next     = ms_clock_ff + SW'(1);
   assign outstanding = lbs_ff - lba_ff;
   assign ack_minus_one = req_ff.rx_ack_number - SW'(1);

   always_comb begin
      phase_in       = phase_ff;
      peer_isn_in    = peer_isn_ff;
      lbs_in         = lbs_ff;
      lba_in         = lba_ff;
      phase_start_in = phase_start_ff;
      ms_clock_in    = ms_clock_ff;
      exhausted_in   = exhausted_ff;
      fin_acked_in   = fin_acked_ff;
      peer_fin_in    = peer_fin_ff;
      peer_last_in   = peer_last_ff;
      slot_we        = 1'b0;
      slot_len_we    = 1'b0;
      slot_waddr     = slot_sent;
      slot_wtime     = ms_clock_ff;
      slot_wlen      = req_ff.chunk_len;
      lba_new        = lba_ff;
      fa_new         = fin_acked_ff;
      pf_new         = peer_fin_ff;
      rsp_in         = '0;

      unique case (req_ff.req_type)
         rts_pkg::REQ_OPEN: begin
            if (phase_ff == rts_pkg::PH_IDLE) begin
               lbs_in           = isn_ff;
               lba_in           = isn_ff;
               exhausted_in     = 1'b0;
               fin_acked_in     = 1'b0;
               peer_fin_in      = 1'b0;
               phase_in         = rts_pkg::PH_SYN;
               phase_start_in   = ms_clock_ff;
               rsp_in.send_seq  = isn_ff;
               rsp_in.send_kind = rts_pkg::SEND_SYN;
            end
         end
         rts_pkg::REQ_HEADER: begin
            if (phase_ff >= rts_pkg::PH_SYN && phase_ff <= rts_pkg::PH_FINW) begin
               peer_last_in = req_ff.rx_seq;
            end
            priority if (phase_ff == rts_pkg::PH_SYN) begin
               if (req_ff.rx_syn && req_ff.rx_ack &&
                   req_ff.rx_ack_number == isn_ff + SW'(1)) begin
                  peer_isn_in      = req_ff.rx_seq;
                  phase_in         = rts_pkg::PH_EST;
                  rsp_in.send_seq  = isn_ff + SW'(1);
                  rsp_in.send_ack  = req_ff.rx_seq + SW'(1);
                  rsp_in.send_kind = rts_pkg::SEND_HS_ACK;
               end
            end else if (phase_ff == rts_pkg::PH_EST) begin
               if (req_ff.rx_ack) begin
                  if (req_ff.rx_ack_number > lba_ff) begin
                     lba_new = (ack_minus_one > lbs_ff) ? lbs_ff : ack_minus_one;
                  end
                  lba_in = lba_new;
                  if (exhausted_ff && lbs_ff == lba_new) begin
                     phase_in         = rts_pkg::PH_FINW;
                     phase_start_in   = ms_clock_ff;
                     fin_acked_in     = 1'b0;
                     peer_fin_in      = 1'b0;
                     rsp_in.send_seq  = lbs_ff + SW'(1);
                     rsp_in.send_ack  = peer_isn_ff + SW'(1);
                     rsp_in.send_kind = rts_pkg::SEND_FIN;
                  end
               end else if (req_ff.rx_fin) begin
                  phase_in         = rts_pkg::PH_FINW;
                  phase_start_in   = ms_clock_ff;
                  fin_acked_in     = 1'b0;
                  peer_fin_in      = 1'b0;
                  rsp_in.send_seq  = lbs_ff + SW'(1);
                  rsp_in.send_ack  = peer_isn_ff + SW'(1);
                  rsp_in.send_kind = rts_pkg::SEND_FIN;
               end
            end else if (phase_ff == rts_pkg::PH_FINW) begin
               fa_new       = fin_acked_ff || req_ff.rx_ack;
               pf_new       = peer_fin_ff || req_ff.rx_fin;
               fin_acked_in = fa_new;
               peer_fin_in  = pf_new;
               if (fa_new && pf_new) begin
                  phase_in         = rts_pkg::PH_CLOSED;
                  rsp_in.send_seq  = lbs_ff + SW'(2);
                  rsp_in.send_ack  = req_ff.rx_seq + SW'(1);
                  rsp_in.send_kind = rts_pkg::SEND_FINAL_ACK;
               end
            end else begin
               phase_in = phase_ff;
            end
         end
         rts_pkg::REQ_CHUNK: begin
            if (phase_ff == rts_pkg::PH_EST && !exhausted_ff &&
                outstanding < rts_pkg::WINDOW_BYTES) begin
               if (req_ff.chunk_len == '0) begin
                  exhausted_in = 1'b1;
                  if (lbs_ff == lba_ff) begin
                     phase_in         = rts_pkg::PH_FINW;
                     phase_start_in   = ms_clock_ff;
                     fin_acked_in     = 1'b0;
                     peer_fin_in      = 1'b0;
                     rsp_in.send_seq  = lbs_ff + SW'(1);
                     rsp_in.send_ack  = peer_isn_ff + SW'(1);
                     rsp_in.send_kind = rts_pkg::SEND_FIN;
                  end
               end else if (req_ff.chunk_len <= rts_pkg::CHUNK_MAX) begin
                  slot_we            = 1'b1;
                  slot_len_we        = 1'b1;
                  slot_waddr         = slot_sent;
                  slot_wtime         = ms_clock_ff;
                  slot_wlen          = req_ff.chunk_len;
                  rsp_in.send_seq    = lbs_ff + SW'(1);
                  rsp_in.send_len    = req_ff.chunk_len;
                  rsp_in.slot        = slot_sent;
                  rsp_in.chunk_taken = 1'b1;
                  rsp_in.send_kind   = rts_pkg::SEND_DATA;
                  lbs_in             = lbs_ff + {{(SW-LW){1'b0}}, req_ff.chunk_len};
               end
            end
         end
         rts_pkg::REQ_TICK: begin
            ms_clock_in = ms_next;
            priority if (phase_ff == rts_pkg::PH_SYN) begin
               if ((ms_next - phase_start_ff) > {{(SW-rts_pkg::TIMEOUT_W){1'b0}}, timeout_ff})
               begin
                  phase_start_in   = ms_next;
                  rsp_in.send_seq  = isn_ff;
                  rsp_in.send_kind = rts_pkg::SEND_SYN;
               end
            end else if (phase_ff == rts_pkg::PH_EST) begin
               if (lbs_ff > lba_ff &&
                   (ms_next - slot_time_ff[slot_acked]) >=
                   {{(SW-rts_pkg::TIMEOUT_W){1'b0}}, timeout_ff}) begin
                  slot_we          = 1'b1;
                  slot_waddr       = slot_acked;
                  slot_wtime       = ms_next;
                  rsp_in.send_seq  = lba_ff + SW'(1);
                  rsp_in.send_len  = slot_len_ff[slot_acked];
                  rsp_in.slot      = slot_acked;
                  rsp_in.send_kind = rts_pkg::SEND_RETX;
               end
            end else if (phase_ff == rts_pkg::PH_FINW) begin
               if ((ms_next - phase_start_ff) >=
                   {{(SW-rts_pkg::TIMEOUT_W){1'b0}}, timeout_ff}) begin
                  phase_in         = rts_pkg::PH_CLOSED;
                  rsp_in.send_seq  = lbs_ff + SW'(2);
                  rsp_in.send_ack  = peer_last_ff + SW'(1);
                  rsp_in.send_kind = rts_pkg::SEND_FINAL_ACK;
               end
            end else begin
               phase_in = phase_ff;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      rsp_in.link_state = phase_in;
   end

   // hold input and result items, advance when the result side frees
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (advance && req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         isn_ff     <= rts_pkg::ISN_RESET;
         timeout_ff <= rts_pkg::TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == rts_pkg::CSR_ISN) begin
            isn_ff <= csr_wdata;
         end
         if (csr_index == rts_pkg::CSR_TIMEOUT) begin
            timeout_ff <= csr_wdata[rts_pkg::TIMEOUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= rts_pkg::PH_IDLE;
         peer_isn_ff    <= '0;
         lbs_ff         <= '0;
         lba_ff         <= '0;
         phase_start_ff <= '0;
         ms_clock_ff    <= '0;
         exhausted_ff   <= 1'b0;
         fin_acked_ff   <= 1'b0;
         peer_fin_ff    <= 1'b0;
         peer_last_ff   <= '0;
      end else if (advance && req_valid_ff) begin
         phase_ff       <= phase_in;
         peer_isn_ff    <= peer_isn_in;
         lbs_ff         <= lbs_in;
         lba_ff         <= lba_in;
         phase_start_ff <= phase_start_in;
         ms_clock_ff    <= ms_clock_in;
         exhausted_ff   <= exhausted_in;
         fin_acked_ff   <= fin_acked_in;
         peer_fin_ff    <= peer_fin_in;
         peer_last_ff   <= peer_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid_ff && slot_we) begin
         slot_time_ff[slot_waddr] <= slot_wtime;
         if (slot_len_we) begin
            slot_len_ff[slot_waddr] <= slot_wlen;
         end
      end
   end

endmodule

// ----- dv/tb_reliable_transport_sender.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for reliable_transport_sender: one connection from open through
// handshake, windowed data, resends and close, with random stalls on both channels.
// Depends on rts_pkg and the reliable_transport_sender RTL.
module tb_reliable_transport_sender;

   localparam logic [rts_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int unsigned MAX_WAIT    = 10;
   localparam int unsigned PHASE_ITEMS = 230;

   class send_scoreboard;
      logic [rts_pkg::SEQ_W-1:0]     isn_reg;
      logic [rts_pkg::TIMEOUT_W-1:0] timeout_reg;
      logic [rts_pkg::PHASE_W-1:0]   link_phase;
      logic [rts_pkg::SEQ_W-1:0]     peer_isn;
      logic [rts_pkg::SEQ_W-1:0]     peer_seq;
      logic [rts_pkg::SEQ_W-1:0]     sent_upto;
      logic [rts_pkg::SEQ_W-1:0]     acked_upto;
      logic [rts_pkg::SEQ_W-1:0]     phase_stamp;
      logic [rts_pkg::SEQ_W-1:0]     tick_count;
      logic [rts_pkg::SEQ_W-1:0]     slot_stamp [rts_pkg::WINDOW_SLOTS];
      logic [rts_pkg::LEN_W-1:0]     slot_bytes [rts_pkg::WINDOW_SLOTS];
      bit                            input_done;
      bit                            fin_acked;
      bit                            peer_fin;
      rts_pkg::rsp_item_type         expected_sends[$];
      int                            items;
      int                            checked;
      int                            failures;
      int                            sends_of_kind [8];

      function new();
         isn_reg     = rts_pkg::ISN_RESET;
         timeout_reg = rts_pkg::TIMEOUT_RESET;
         link_phase  = rts_pkg::PH_IDLE;
         peer_isn    = '0;
         peer_seq    = '0;
         sent_upto   = '0;
         acked_upto  = '0;
         phase_stamp = '0;
         tick_count  = '0;
         foreach (slot_stamp[i]) begin
            slot_stamp[i] = '0;
            slot_bytes[i] = '0;
         end
         foreach (sends_of_kind[k]) sends_of_kind[k] = 0;
      endfunction

      function void write_reg(logic [rts_pkg::CSR_INDEX_W-1:0] index,
                              logic [rts_pkg::SEQ_W-1:0] value);
         if (index == rts_pkg::CSR_ISN) isn_reg = value;
         else if (index == rts_pkg::CSR_TIMEOUT) timeout_reg = value[rts_pkg::TIMEOUT_W-1:0];
      endfunction

      function logic [rts_pkg::SLOT_W-1:0] slot_for(logic [rts_pkg::SEQ_W-1:0] byte_num);
         return rts_pkg::SLOT_W'(byte_num >> rts_pkg::CHUNK_SHIFT);
      endfunction

      function void start_fin(inout rts_pkg::rsp_item_type e);
         link_phase  = rts_pkg::PH_FINW;
         phase_stamp = tick_count;
         fin_acked   = 1'b0;
         peer_fin    = 1'b0;
         e.send_kind = rts_pkg::SEND_FIN;
         e.send_seq  = sent_upto + 1;
         e.send_ack  = peer_isn + 1;
      endfunction

      function void close_link(inout rts_pkg::rsp_item_type e);
         link_phase  = rts_pkg::PH_CLOSED;
         e.send_kind = rts_pkg::SEND_FINAL_ACK;
         e.send_seq  = sent_upto + 2;
         e.send_ack  = peer_seq + 1;
      endfunction

      function void note_request(rts_pkg::req_item_type req);
         rts_pkg::rsp_item_type      e;
         logic [rts_pkg::SLOT_W-1:0] s;
         logic [rts_pkg::SEQ_W-1:0]  diff;
         e = '0;
         items++;
         case (req.req_type)
            rts_pkg::REQ_OPEN: begin
               if (link_phase == rts_pkg::PH_IDLE) begin
                  sent_upto   = isn_reg;
                  acked_upto  = isn_reg;
                  input_done  = 1'b0;
                  fin_acked   = 1'b0;
                  peer_fin    = 1'b0;
                  link_phase  = rts_pkg::PH_SYN;
                  phase_stamp = tick_count;
                  e.send_kind = rts_pkg::SEND_SYN;
                  e.send_seq  = isn_reg;
               end
            end
            rts_pkg::REQ_HEADER: begin
               if (link_phase >= rts_pkg::PH_SYN && link_phase <= rts_pkg::PH_FINW)
                  peer_seq = req.rx_seq;
               if (link_phase == rts_pkg::PH_SYN) begin
                  if (req.rx_syn && req.rx_ack && req.rx_ack_number == isn_reg + 1) begin
                     peer_isn    = req.rx_seq;
                     link_phase  = rts_pkg::PH_EST;
                     e.send_kind = rts_pkg::SEND_HS_ACK;
                     e.send_seq  = isn_reg + 1;
                     e.send_ack  = req.rx_seq + 1;
                  end
               end else if (link_phase == rts_pkg::PH_EST) begin
                  if (req.rx_ack) begin
                     if (req.rx_ack_number > acked_upto) begin
                        diff = req.rx_ack_number - 1;
                        acked_upto = (diff > sent_upto) ? sent_upto : diff;
                     end
                     if (input_done && sent_upto == acked_upto) start_fin(e);
                  end else if (req.rx_fin) begin
                     start_fin(e);
                  end
               end else if (link_phase == rts_pkg::PH_FINW) begin
                  if (req.rx_ack) fin_acked = 1'b1;
                  if (req.rx_fin) peer_fin = 1'b1;
                  if (fin_acked && peer_fin) close_link(e);
               end
            end
            rts_pkg::REQ_CHUNK: begin
               diff = sent_upto - acked_upto;
               if (link_phase == rts_pkg::PH_EST && !input_done &&
                   diff < rts_pkg::WINDOW_BYTES) begin
                  if (req.chunk_len == '0) begin
                     input_done = 1'b1;
                     if (sent_upto == acked_upto) start_fin(e);
                  end else if (req.chunk_len <= rts_pkg::CHUNK_MAX) begin
                     s = slot_for(sent_upto);
                     slot_bytes[s] = req.chunk_len;
                     slot_stamp[s] = tick_count;
                     e.send_kind   = rts_pkg::SEND_DATA;
                     e.send_seq    = sent_upto + 1;
                     e.send_len    = req.chunk_len;
                     e.slot        = s;
                     e.chunk_taken = 1'b1;
                     sent_upto     = sent_upto + rts_pkg::SEQ_W'(req.chunk_len);
                  end
               end
            end
            default: begin
               tick_count = tick_count + 1;
               if (link_phase == rts_pkg::PH_SYN) begin
                  diff = tick_count - phase_stamp;
                  if (diff > rts_pkg::SEQ_W'(timeout_reg)) begin
                     phase_stamp = tick_count;
                     e.send_kind = rts_pkg::SEND_SYN;
                     e.send_seq  = isn_reg;
                  end
               end else if (link_phase == rts_pkg::PH_EST) begin
                  if (sent_upto > acked_upto) begin
                     s = slot_for(acked_upto);
                     diff = tick_count - slot_stamp[s];
                     if (diff >= rts_pkg::SEQ_W'(timeout_reg)) begin
                        slot_stamp[s] = tick_count;
                        e.send_kind   = rts_pkg::SEND_RETX;
                        e.send_seq    = acked_upto + 1;
                        e.send_len    = slot_bytes[s];
                        e.slot        = s;
                     end
                  end
               end else if (link_phase == rts_pkg::PH_FINW) begin
                  diff = tick_count - phase_stamp;
                  if (diff >= rts_pkg::SEQ_W'(timeout_reg)) close_link(e);
               end
            end
         endcase
         e.link_state = link_phase;
         sends_of_kind[e.send_kind]++;
         expected_sends.push_back(e);
      endfunction

      function void check_send(rts_pkg::rsp_item_type got);
         rts_pkg::rsp_item_type want;
         if (expected_sends.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected send: kind %0d seq %h ack %h state %0d",
                        got.send_kind, got.send_seq, got.send_ack, got.link_state);
            return;
         end
         want = expected_sends.pop_front();
         checked++;
         if (got.send_kind !== want.send_kind || got.send_seq !== want.send_seq ||
             got.send_ack !== want.send_ack || got.send_len !== want.send_len ||
             got.slot !== want.slot || got.chunk_taken !== want.chunk_taken ||
             got.link_state !== want.link_state) begin
            failures++;
            if (failures <= 10) begin
               $display("send %0d mismatch: expected kind %0d seq %h ack %h len %0d",
                        checked, want.send_kind, want.send_seq, want.send_ack,
                        want.send_len);
               $display("   expected slot %0d taken %0d state %0d",
                        want.slot, want.chunk_taken, want.link_state);
               $display("   actual kind %0d seq %h ack %h len %0d slot %0d taken %0d state %0d",
                        got.send_kind, got.send_seq, got.send_ack, got.send_len,
                        got.slot, got.chunk_taken, got.link_state);
            end
         end
      endfunction

      function int pending();
         return expected_sends.size();
      endfunction
   endclass

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   rts_pkg::req_item_type           req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   rts_pkg::rsp_item_type           rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [rts_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [rts_pkg::SEQ_W-1:0]       csr_wdata = '0;

   send_scoreboard sb;
   bit             req_burst;
   bit             rsp_burst;

   always #5ns clock = ~clock;

   reliable_transport_sender i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   function automatic bit coin();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic int draw_wait(inout bit burst);
      if ($urandom_range(0, 31) == 0) burst = !burst;
      return burst ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic rts_pkg::req_item_type noise_item();
      rts_pkg::req_item_type r;
      r.req_type      = 2'($urandom);
      r.rx_syn        = coin();
      r.rx_ack        = coin();
      r.rx_fin        = coin();
      r.rx_seq        = $urandom;
      r.rx_ack_number = $urandom;
      r.chunk_len     = rts_pkg::LEN_W'($urandom);
      return r;
   endfunction

   function automatic logic [rts_pkg::SEQ_W-1:0] pick_ack();
      logic [rts_pkg::SEQ_W-1:0] span;
      int unsigned               pick;
      span = sb.sent_upto - sb.acked_upto;
      pick = $urandom_range(0, 99);
      if (pick < 70) return sb.acked_upto + 1 + $urandom_range(0, span);
      if (pick < 85) return $urandom_range(0, sb.acked_upto);
      return $urandom;
   endfunction

   task automatic drive_request(input rts_pkg::req_item_type req);
      int gap;
      gap = draw_wait(req_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req;
      do @(posedge clock); while (!req_ready);
      sb.note_request(req);
   endtask

   task automatic drive_header(input logic syn, input logic ack, input logic fin,
                               input logic [rts_pkg::SEQ_W-1:0] seq,
                               input logic [rts_pkg::SEQ_W-1:0] ackn);
      rts_pkg::req_item_type r;
      r = noise_item();
      r.req_type      = rts_pkg::REQ_HEADER;
      r.rx_syn        = syn;
      r.rx_ack        = ack;
      r.rx_fin        = fin;
      r.rx_seq        = seq;
      r.rx_ack_number = ackn;
      drive_request(r);
   endtask

   task automatic send_chunk(input logic [rts_pkg::LEN_W-1:0] len);
      rts_pkg::req_item_type r;
      r = noise_item();
      r.req_type  = rts_pkg::REQ_CHUNK;
      r.chunk_len = len;
      drive_request(r);
   endtask

   task automatic send_other(input logic [1:0] kind);
      rts_pkg::req_item_type r;
      r = noise_item();
      r.req_type = kind;
      drive_request(r);
   endtask

   // hold off until every expected send is back and the pipeline is empty
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rts_pkg::CSR_INDEX_W-1:0] index,
                            input logic [rts_pkg::SEQ_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_reg(index, value);
   endtask

   task automatic est_step();
      int unsigned pick;
      int unsigned c;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         c = $urandom_range(0, 19);
         if (c == 0) send_chunk(rts_pkg::CHUNK_MAX);
         else if (c == 1)
            send_chunk(rts_pkg::LEN_W'($urandom_range(rts_pkg::CHUNK_BYTES + 1,
                                                      (1 << rts_pkg::LEN_W) - 1)));
         else send_chunk(rts_pkg::LEN_W'($urandom_range(1, rts_pkg::CHUNK_BYTES)));
      end else if (pick < 65) begin
         drive_header(coin(), 1'b1, coin(), $urandom, pick_ack());
      end else if (pick < 92) begin
         send_other(rts_pkg::REQ_TICK);
      end else if (pick < 96) begin
         send_other(rts_pkg::REQ_OPEN);
      end else begin
         drive_header(coin(), 1'b0, 1'b0, $urandom, $urandom);
      end
   endtask

   initial begin
      int stall;
      wait (reset == 1'b0);
      forever begin
         stall = draw_wait(rsp_burst);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_send(rsp_data);
      end
   end

   initial begin
      logic [rts_pkg::TIMEOUT_W-1:0] tmo;
      int                            guard;
      int unsigned                   pick;
      bit                            close_by_fin;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_reg(rts_pkg::CSR_TIMEOUT, 32'd1);
      write_reg(rts_pkg::CSR_ISN, 32'd0);
      send_other(rts_pkg::REQ_TICK);
      drive_header(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_chunk(rts_pkg::CHUNK_MAX);
      send_other(rts_pkg::REQ_OPEN);
      send_other(rts_pkg::REQ_OPEN);
      send_other(rts_pkg::REQ_TICK);
      send_other(rts_pkg::REQ_TICK);
      drive_header(1'b1, 1'b1, 1'b0, 32'h0, 32'h0);
      drive_header(1'b1, 1'b0, 1'b0, 32'h0, 32'h1);
      write_reg(rts_pkg::CSR_ISN, 32'hFFFF_FFFF);
      send_other(rts_pkg::REQ_TICK);
      send_other(rts_pkg::REQ_TICK);
      drive_header(1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0);
      // fill every slot once before any ack can point into the window
      repeat (7) send_chunk(rts_pkg::CHUNK_MAX);
      send_chunk(rts_pkg::LEN_W'((1 << rts_pkg::LEN_W) - 1));
      send_chunk(rts_pkg::CHUNK_MAX);
      send_chunk(rts_pkg::LEN_W'(1));
      send_chunk('0);
      send_other(rts_pkg::REQ_TICK);
      drive_header(1'b0, 1'b1, 1'b1, $urandom, 32'd1025);
      drive_header(1'b0, 1'b1, 1'b0, 32'h0, 32'hFFFF_FFFF);

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: tmo = 16'd1;
            1: tmo = 16'hFFFF;
            2: tmo = 16'($urandom_range(2, 6));
            3: tmo = 16'($urandom_range(8, 40));
            4: tmo = rts_pkg::TIMEOUT_RESET;
            default: tmo = 16'($urandom_range(1, 4));
         endcase
         write_reg(rts_pkg::CSR_TIMEOUT, {16'($urandom), tmo});
         if (p % 2 == 1) write_reg(rts_pkg::CSR_ISN, $urandom);
         if (p == 2) write_reg(CSR_UNMAPPED, $urandom);
         repeat (PHASE_ITEMS) est_step();
      end

      close_by_fin = coin();
      write_reg(rts_pkg::CSR_TIMEOUT, $urandom_range(1, 12));
      guard = 0;
      while (sb.link_phase != rts_pkg::PH_CLOSED && guard < 600) begin
         guard++;
         pick = $urandom_range(0, 99);
         if (sb.link_phase == rts_pkg::PH_EST) begin
            if (pick < 20) begin
               if (close_by_fin) drive_header(coin(), 1'b0, 1'b1, $urandom, $urandom);
               else send_chunk('0);
            end else if (pick < 60) begin
               drive_header(coin(), 1'b1, coin(), $urandom,
                            coin() ? sb.sent_upto + 1 : pick_ack());
            end else if (pick < 80) begin
               send_other(rts_pkg::REQ_TICK);
            end else begin
               send_chunk(rts_pkg::LEN_W'($urandom_range(1, rts_pkg::CHUNK_BYTES)));
            end
         end else if (pick < 50) begin
            drive_header(coin(), coin(), coin(), $urandom, $urandom);
         end else begin
            send_other(rts_pkg::REQ_TICK);
         end
      end
      repeat (20) est_step();

      settle();
      $display("%0d items, %0d sends checked: %0d SYN, %0d handshake ACK, %0d data",
               sb.items, sb.checked, sb.sends_of_kind[rts_pkg::SEND_SYN],
               sb.sends_of_kind[rts_pkg::SEND_HS_ACK], sb.sends_of_kind[rts_pkg::SEND_DATA]);
      $display("%0d resend, %0d FIN, %0d final ACK; link closed %s, %0d silent, %0d failures",
               sb.sends_of_kind[rts_pkg::SEND_RETX], sb.sends_of_kind[rts_pkg::SEND_FIN],
               sb.sends_of_kind[rts_pkg::SEND_FINAL_ACK],
               close_by_fin ? "by a server FIN" : "after end of input",
               sb.sends_of_kind[rts_pkg::SEND_NONE], sb.failures);
      if (sb.failures == 0) begin
         $display("tb_reliable_transport_sender: PASS");
      end else begin
         $display("tb_reliable_transport_sender: FAIL");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_reliable_transport_sender: FAIL");
      $finish;
   end

endmodule
